// ----- hdl/wsd_pkg.sv -----
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared constants and codes for the websocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Field widths
  localparam int unsigned ByteW   = 8;
  localparam int unsigned OpW     = 4;
  localparam int unsigned KindW   = 2;
  localparam int unsigned MaxLenW = 32;
  localparam int unsigned LenW    = 64;
  localparam int unsigned KeyW    = 32;
  localparam int unsigned CfgIdxW = 1;

  // Register indexes
  localparam logic [CfgIdxW-1:0] REG_MAX_FRAME_LEN   = 1'd0;
  localparam logic [CfgIdxW-1:0] REG_ACCEPT_UNMASKED = 1'd1;

  // Reset value of the frame length limit (32 MiB)
  localparam logic [MaxLenW-1:0] MAX_LEN_RESET = 32'd33554432;

  // Result kinds
  localparam logic [KindW-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KindW-1:0] KIND_END     = 2'd1;
  localparam logic [KindW-1:0] KIND_PONG    = 2'd2;
  localparam logic [KindW-1:0] KIND_ERROR   = 2'd3;

  // Error codes
  localparam logic ERR_UNMASKED = 1'b0;
  localparam logic ERR_TOO_LONG = 1'b1;

  // Opcodes and length escapes
  localparam logic [OpW-1:0] OP_CONT      = 4'd0;
  localparam logic [OpW-1:0] OP_BINARY    = 4'd2;
  localparam logic [OpW-1:0] OP_PING      = 4'd9;
  localparam logic [6:0]     LEN16_CODE   = 7'd126;
  localparam logic [6:0]     LEN64_CODE   = 7'd127;

  // One result item
  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [ByteW-1:0] payload_byte;
    logic [OpW-1:0]   message_opcode;
    logic             last;
    logic             error_code;
  } wsd_result_t;

endpackage

// ----- hdl/wsd_in_if.sv -----
// ----------------------------------------------------------------------------
// wsd_in_if
// Received byte channel: valid/ready with one stream byte.
// ----------------------------------------------------------------------------
interface wsd_in_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

// ----- hdl/wsd_out_if.sv -----
// ----------------------------------------------------------------------------
// wsd_out_if
// Result channel: valid/ready with one deframer result.
// ----------------------------------------------------------------------------
interface wsd_out_if import wsd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KindW-1:0] kind;
  logic [ByteW-1:0] payload_byte;
  logic [OpW-1:0]   message_opcode;
  logic             last;
  logic             error_code;

  modport source (output valid, output kind, output payload_byte, output message_opcode,
                  output last, output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte, input message_opcode,
                  input last, input error_code, output ready);
endinterface

// ----- hdl/websocket_frame_deframer_top.sv -----
// A result is registered: it is on the output in the cycle after the byte that causes it is accepted.
// One byte per cycle while the result register is empty or draining; it is refilled in the cycle it drains.
// Each byte is one combinational parser step; the 64-bit length decrement and compare set the path.
// Reset (rst, synchronous, active high) returns the parser to the first header byte,
// clears the result valid flag and loads the register defaults (limit 32 MiB, mask required).
// ----------------------------------------------------------------------------
// websocket_frame_deframer_top
// Receive-side frame parser: header, extended length, mask key, unmasked payload.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_top import wsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [MaxLenW-1:0] cfg_data,
  wsd_in_if.sink             rx_bytes,
  wsd_out_if.source          results
);

  // Parser phases
  localparam logic [2:0] PH_HDR0    = 3'd0;
  localparam logic [2:0] PH_HDR1    = 3'd1;
  localparam logic [2:0] PH_EXTLEN  = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;
  localparam logic [2:0] PH_HALT    = 3'd5;

  // Configuration
  logic [MaxLenW-1:0] max_frame_len;
  logic               accept_unmasked;

  // Parser state
  logic [2:0]      phase, phase_next;
  logic            final_flag, final_flag_next;
  logic [OpW-1:0]  frame_opcode, frame_opcode_next;
  logic            masked_flag, masked_flag_next;
  logic [3:0]      bytes_left, bytes_left_next;
  logic [LenW-1:0] frame_length, frame_length_next;
  logic [KeyW-1:0] mask_key, mask_key_next;
  logic [1:0]      mask_position, mask_position_next;
  logic [OpW-1:0]  msg_opcode, msg_opcode_next;

  // Result register
  logic        out_valid;
  wsd_result_t out_res;

  // Step outputs
  logic        emit;
  wsd_result_t res;

  // Step helpers
  logic            accept;
  logic [ByteW-1:0] b;
  logic            is_data;
  logic            len_done;
  logic [LenW-1:0] len_val;
  logic            bp_go;
  logic [ByteW-1:0] key_byte;

  assign b        = rx_bytes.data_byte;
  assign is_data  = (frame_opcode <= OP_BINARY);
  assign accept   = rx_bytes.valid && rx_bytes.ready;
  assign key_byte = mask_key[{~mask_position, 3'b000} +: ByteW];

  // Input is taken whenever the result register is empty or draining
  assign rx_bytes.ready = !out_valid || results.ready;

  // One parser step per accepted byte
  always_comb begin
    phase_next         = phase;
    final_flag_next    = final_flag;
    frame_opcode_next  = frame_opcode;
    masked_flag_next   = masked_flag;
    bytes_left_next    = bytes_left;
    frame_length_next  = frame_length;
    mask_key_next      = mask_key;
    mask_position_next = mask_position;
    msg_opcode_next    = msg_opcode;
    emit               = 1'b0;
    res                = '0;
    len_done           = 1'b0;
    len_val            = '0;
    bp_go              = 1'b0;

    case (phase)
      PH_HDR0: begin
        final_flag_next   = b[7];
        frame_opcode_next = b[OpW-1:0];
        phase_next        = PH_HDR1;
      end
      PH_HDR1: begin
        masked_flag_next = b[7];
        if (is_data && !b[7] && !accept_unmasked) begin
          phase_next     = PH_HALT;
          emit           = 1'b1;
          res.kind       = KIND_ERROR;
          res.error_code = ERR_UNMASKED;
        end else begin
          if (is_data && msg_opcode == OP_CONT && frame_opcode != OP_CONT) begin
            msg_opcode_next = frame_opcode;
          end
          frame_length_next = '0;
          if (b[6:0] == LEN16_CODE || b[6:0] == LEN64_CODE) begin
            bytes_left_next = (b[6:0] == LEN16_CODE) ? 4'd2 : 4'd8;
            phase_next      = PH_EXTLEN;
          end else begin
            len_done = 1'b1;
            len_val  = {{(LenW-7){1'b0}}, b[6:0]};
          end
        end
      end
      PH_EXTLEN: begin
        len_val           = {frame_length[LenW-ByteW-1:0], b};
        frame_length_next = len_val;
        bytes_left_next   = bytes_left - 4'd1;
        len_done          = (bytes_left == 4'd1);
      end
      PH_MASK: begin
        mask_key_next   = {mask_key[KeyW-ByteW-1:0], b};
        bytes_left_next = bytes_left - 4'd1;
        bp_go           = (bytes_left == 4'd1);
      end
      PH_PAYLOAD: begin
        mask_position_next = mask_position + 2'd1;
        frame_length_next  = frame_length - {{(LenW-1){1'b0}}, 1'b1};
        if (is_data) begin
          emit               = 1'b1;
          res.kind           = KIND_PAYLOAD;
          res.payload_byte   = masked_flag ? (b ^ key_byte) : b;
          res.message_opcode = msg_opcode;
          res.last           = final_flag && (frame_length == {{(LenW-1){1'b0}}, 1'b1});
        end
        if (frame_length == {{(LenW-1){1'b0}}, 1'b1}) begin
          phase_next = PH_HDR0;
          if (is_data && final_flag) msg_opcode_next = OP_CONT;
        end
      end
      default: begin
        phase_next = PH_HALT;
      end
    endcase

    // Full length known: limit check, then mask key or payload
    if (len_done) begin
      frame_length_next = len_val;
      if (is_data && len_val > {{(LenW-MaxLenW){1'b0}}, max_frame_len}) begin
        phase_next     = PH_HALT;
        emit           = 1'b1;
        res            = '0;
        res.kind       = KIND_ERROR;
        res.error_code = ERR_TOO_LONG;
      end else if (masked_flag_next) begin
        phase_next      = PH_MASK;
        bytes_left_next = 4'd4;
        mask_key_next   = '0;
      end else begin
        mask_key_next = '0;
        bp_go         = 1'b1;
      end
    end

    // Payload start; an empty frame ends here
    if (bp_go) begin
      mask_position_next = 2'd0;
      if (frame_length_next != '0) begin
        phase_next = PH_PAYLOAD;
      end else begin
        phase_next = PH_HDR0;
        if (is_data && final_flag) begin
          emit               = 1'b1;
          res                = '0;
          res.kind           = KIND_END;
          res.message_opcode = msg_opcode_next;
          res.last           = 1'b1;
          msg_opcode_next    = OP_CONT;
        end
      end
    end

    // Ping header answers with a pong request
    if (phase == PH_HDR1 && frame_opcode == OP_PING) begin
      emit     = 1'b1;
      res      = '0;
      res.kind = KIND_PONG;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_frame_len   <= MAX_LEN_RESET;
      accept_unmasked <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_MAX_FRAME_LEN:   max_frame_len   <= cfg_data;
        REG_ACCEPT_UNMASKED: accept_unmasked <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HDR0;
      final_flag    <= 1'b0;
      frame_opcode  <= '0;
      masked_flag   <= 1'b0;
      bytes_left    <= '0;
      frame_length  <= '0;
      mask_key      <= '0;
      mask_position <= '0;
      msg_opcode    <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      final_flag    <= final_flag_next;
      frame_opcode  <= frame_opcode_next;
      masked_flag   <= masked_flag_next;
      bytes_left    <= bytes_left_next;
      frame_length  <= frame_length_next;
      mask_key      <= mask_key_next;
      mask_position <= mask_position_next;
      msg_opcode    <= msg_opcode_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= emit;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      out_res <= res;
    end
  end

  assign results.valid          = out_valid;
  assign results.kind           = out_res.kind;
  assign results.payload_byte   = out_res.payload_byte;
  assign results.message_opcode = out_res.message_opcode;
  assign results.last           = out_res.last;
  assign results.error_code     = out_res.error_code;

`ifndef ASSERT_OFF
  // Phase code stays within the defined phases
  a_phase_range: assert property (@(posedge clk) disable iff (rst)
    phase <= PH_HALT)
    else $error("parser phase out of range");

  // Halt is sticky until reset
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    phase == PH_HALT |=> phase == PH_HALT)
    else $error("parser left halt without reset");

  // A pending error result implies the parser is halted
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_res.kind == KIND_ERROR |-> phase == PH_HALT)
    else $error("error reported but parser not halted");

  // No result is produced once halted
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_HALT |-> !emit)
    else $error("result produced while halted");

  // Payload phase always has bytes left to consume
  a_payload_len: assert property (@(posedge clk) disable iff (rst)
    phase == PH_PAYLOAD |-> frame_length != '0)
    else $error("payload phase with zero length");
`endif

endmodule
